FILE: design/kalman_filter_update_top_macros.svh
// Assertion macros for the Kalman filter update block.
`ifndef KALMAN_FILTER_UPDATE_TOP_MACROS_SVH
`define KALMAN_FILTER_UPDATE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define KFU_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define KFU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define KFU_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define KFU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: design/kfu_pkg.sv
// ----------------------------------------------------------------------------
// Kalman filter update package
// Payload types, status codes and register indexes shared by the block.
// ----------------------------------------------------------------------------
package kfu_pkg;

	localparam int CFG_IDX_BITS = 3;
	localparam int CFG_BITS = 64;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_DYN0 = 3'd0, REG_DYN1 = 3'd1, REG_OUT = 3'd2, REG_Q0 = 3'd3,
		REG_Q1 = 3'd4, REG_RDT = 3'd5, REG_P0 = 3'd6, REG_P1 = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0, ST_NOT_READY = 2'd1, ST_SINGULAR = 2'd2, ST_RSVD = 2'd3
	} status_t;

	typedef struct packed {
		logic               kind;
		logic signed [31:0] measurement;
		logic signed [31:0] init_state0;
		logic signed [31:0] init_state1;
		logic signed [31:0] start_time;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] estimate0;
		logic signed [31:0] estimate1;
		logic signed [31:0] elapsed_time;
		logic [1:0]         status;
	} out_item_t;

endpackage

FILE: design/kfu_divider.sv
// ----------------------------------------------------------------------------
// Kalman filter fixed-point divider
// Restoring divider, one quotient bit per cycle, truncating and saturating.
// ----------------------------------------------------------------------------
module kfu_divider import kfu_pkg::*; #(
	parameter int FRAC_BITS = 16,
	parameter int WORD_BITS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic signed [WORD_BITS-1:0] num,
	input  logic signed [WORD_BITS-1:0] den,
	output logic                        done,
	output logic signed [WORD_BITS-1:0] quo
);

	localparam int QW = WORD_BITS + FRAC_BITS;
	localparam int CW = $clog2(QW + 1);

	logic [QW-1:0]        dividend_q;
	logic [QW-1:0]        q_q;
	logic [WORD_BITS:0]   r_q;
	logic [WORD_BITS-1:0] d_q;
	logic                 neg_q;
	logic                 busy_q;
	logic [CW-1:0]        cnt_q;
	logic [WORD_BITS:0]   r_sh;
	logic [WORD_BITS:0]   r_sub;
	logic [QW:0]          lim;

	// Shift in one dividend bit and try a subtraction.
	assign r_sh  = {r_q[WORD_BITS-1:0], dividend_q[QW-1]};
	assign r_sub = r_sh - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q     <= 1'b1;
				cnt_q      <= CW'(QW);
				neg_q      <= num[WORD_BITS-1];
				dividend_q <= {(num[WORD_BITS-1] ? -num : num), {FRAC_BITS{1'b0}}};
				d_q        <= den;
				r_q        <= '0;
				q_q        <= '0;
			end else if (busy_q) begin
				dividend_q <= dividend_q << 1;
				if (!r_sub[WORD_BITS]) begin
					r_q <= r_sub;
					q_q <= {q_q[QW-2:0], 1'b1};
				end else begin
					r_q <= r_sh;
					q_q <= {q_q[QW-2:0], 1'b0};
				end
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	// Saturate the magnitude and apply the sign.
	always_comb begin
		lim = neg_q ? ((QW+1)'(1) << (WORD_BITS - 1)) : (((QW+1)'(1) << (WORD_BITS - 1)) - 1'b1);
		if ({1'b0, q_q} > lim) begin
			quo = neg_q ? {1'b1, {(WORD_BITS-1){1'b0}}} : {1'b0, {(WORD_BITS-1){1'b1}}};
		end else begin
			quo = neg_q ? -q_q[WORD_BITS-1:0] : q_q[WORD_BITS-1:0];
		end
	end

endmodule

FILE: design/kalman_filter_update_top.sv
// Results: an initialise or not-initialised item has its result valid in the cycle after
// the input transfer. A measurement runs 32 micro-steps, each through S_MUL1, S_MUL2 and
// S_ACC, with two divider passes between step 17 and step 18; when the innovation
// variance is singular it ends after step 17 with no divider pass.
// Throughput: one item at a time; the next input transfer can follow in the cycle after the
// result transfer. Reset: state cleared, filter not initialised, registers at reset.
// ----------------------------------------------------------------------------
// Kalman filter update top level
// Two-state scalar-measurement Kalman filter on one shared multiply-add unit.
// ----------------------------------------------------------------------------
`include "kalman_filter_update_top_macros.svh"
module kalman_filter_update_top import kfu_pkg::*; #(
	parameter int FRAC_BITS = 16,
	parameter int WORD_BITS = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  in_item_t                in_data,
	output logic                    out_valid,
	input  logic                    out_ready,
	output out_item_t               out_data,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_idx,
	input  logic [CFG_BITS-1:0]     cfg_data
);

	localparam int W  = WORD_BITS;
	localparam int IW = (WORD_BITS < 32) ? WORD_BITS : 32;
	localparam int PW = 2 * W;
	localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
	localparam logic signed [W:0] ONE_WIDE = (W+1)'(1) <<< FRAC_BITS;

	// Register-file slot numbers for the working values. Values whose lifetimes do not
	// overlap share a slot: the process noise is dead once the predicted covariance is formed,
	// R once S is formed, and the A.P products are dead before the I - K.C terms are built.
	localparam int NV = 31;
	localparam int VB = 5;
	localparam logic [VB-1:0] V_A00 = 0, V_A01 = 1, V_A10 = 2, V_A11 = 3,
		V_C0 = 4, V_C1 = 5, V_Q00 = 6, V_Q01 = 7, V_Q10 = 8, V_Q11 = 9,
		V_R = 10, V_X0 = 11, V_X1 = 12, V_P00 = 13, V_P01 = 14, V_P10 = 15,
		V_P11 = 16, V_XP0 = 17, V_XP1 = 18, V_AP0 = 19, V_AP1 = 20,
		V_AP2 = 21, V_AP3 = 22, V_PP0 = 23, V_PP1 = 24, V_PP2 = 25,
		V_PP3 = 26, V_Y = 27, V_INN = 28, V_ZERO = 29, V_ONE = 30,
		V_PC0 = 6, V_PC1 = 7, V_S = 8, V_K0 = 9, V_K1 = 10,
		V_M0 = 19, V_M1 = 20, V_M2 = 21, V_M3 = 22;

	// Microcode: dest = sat(sat(a*b) + sat(c*d)), a + e, e - sat(a*b) or a - e by mode.
	typedef enum logic [1:0] { OP_DOT, OP_ADD, OP_SUBMUL, OP_SUB } op_t;
	typedef struct packed {
		op_t           op;
		logic [VB-1:0] a, b, c, d, e, dst;
	} uop_t;

	localparam int UB = 6;

	function automatic uop_t ucode(input logic [UB-1:0] i);
		uop_t u;
		u = '{OP_DOT, V_ZERO, V_ZERO, V_ZERO, V_ZERO, V_ZERO, V_ZERO};
		unique case (i)
			6'd0:  u = '{OP_DOT, V_A00, V_X0, V_A01, V_X1, V_ZERO, V_XP0};
			6'd1:  u = '{OP_DOT, V_A10, V_X0, V_A11, V_X1, V_ZERO, V_XP1};
			6'd2:  u = '{OP_DOT, V_A00, V_P00, V_A01, V_P10, V_ZERO, V_AP0};
			6'd3:  u = '{OP_DOT, V_A00, V_P01, V_A01, V_P11, V_ZERO, V_AP1};
			6'd4:  u = '{OP_DOT, V_A10, V_P00, V_A11, V_P10, V_ZERO, V_AP2};
			6'd5:  u = '{OP_DOT, V_A10, V_P01, V_A11, V_P11, V_ZERO, V_AP3};
			6'd6:  u = '{OP_DOT, V_AP0, V_A00, V_AP1, V_A01, V_ZERO, V_PP0};
			6'd7:  u = '{OP_ADD, V_PP0, V_ZERO, V_ZERO, V_ZERO, V_Q00, V_PP0};
			6'd8:  u = '{OP_DOT, V_AP0, V_A10, V_AP1, V_A11, V_ZERO, V_PP1};
			6'd9:  u = '{OP_ADD, V_PP1, V_ZERO, V_ZERO, V_ZERO, V_Q01, V_PP1};
			6'd10: u = '{OP_DOT, V_AP2, V_A00, V_AP3, V_A01, V_ZERO, V_PP2};
			6'd11: u = '{OP_ADD, V_PP2, V_ZERO, V_ZERO, V_ZERO, V_Q10, V_PP2};
			6'd12: u = '{OP_DOT, V_AP2, V_A10, V_AP3, V_A11, V_ZERO, V_PP3};
			6'd13: u = '{OP_ADD, V_PP3, V_ZERO, V_ZERO, V_ZERO, V_Q11, V_PP3};
			6'd14: u = '{OP_DOT, V_PP0, V_C0, V_PP1, V_C1, V_ZERO, V_PC0};
			6'd15: u = '{OP_DOT, V_PP2, V_C0, V_PP3, V_C1, V_ZERO, V_PC1};
			6'd16: u = '{OP_DOT, V_C0, V_PC0, V_C1, V_PC1, V_ZERO, V_S};
			6'd17: u = '{OP_ADD, V_S, V_ZERO, V_ZERO, V_ZERO, V_R, V_S};
			// Divisions run between step 17 and step 18.
			6'd18: u = '{OP_DOT, V_C0, V_XP0, V_C1, V_XP1, V_ZERO, V_INN};
			6'd19: u = '{OP_SUB, V_Y, V_ZERO, V_ZERO, V_ZERO, V_INN, V_INN};
			6'd20: u = '{OP_DOT, V_K0, V_INN, V_ZERO, V_ZERO, V_ZERO, V_X0};
			6'd21: u = '{OP_ADD, V_X0, V_ZERO, V_ZERO, V_ZERO, V_XP0, V_X0};
			6'd22: u = '{OP_DOT, V_K1, V_INN, V_ZERO, V_ZERO, V_ZERO, V_X1};
			6'd23: u = '{OP_ADD, V_X1, V_ZERO, V_ZERO, V_ZERO, V_XP1, V_X1};
			6'd24: u = '{OP_SUBMUL, V_K0, V_C0, V_ZERO, V_ZERO, V_ONE, V_M0};
			6'd25: u = '{OP_SUBMUL, V_K0, V_C1, V_ZERO, V_ZERO, V_ZERO, V_M1};
			6'd26: u = '{OP_SUBMUL, V_K1, V_C0, V_ZERO, V_ZERO, V_ZERO, V_M2};
			6'd27: u = '{OP_SUBMUL, V_K1, V_C1, V_ZERO, V_ZERO, V_ONE, V_M3};
			6'd28: u = '{OP_DOT, V_M0, V_PP0, V_M1, V_PP2, V_ZERO, V_P00};
			6'd29: u = '{OP_DOT, V_M0, V_PP1, V_M1, V_PP3, V_ZERO, V_P01};
			6'd30: u = '{OP_DOT, V_M2, V_PP0, V_M3, V_PP2, V_ZERO, V_P10};
			6'd31: u = '{OP_DOT, V_M2, V_PP1, V_M3, V_PP3, V_ZERO, V_P11};
			default: u = '{OP_DOT, V_ZERO, V_ZERO, V_ZERO, V_ZERO, V_ZERO, V_ZERO};
		endcase
		return u;
	endfunction

	function automatic logic signed [W-1:0] sat_w(input logic signed [W+1:0] v);
		if (v > $signed({{2{WMAX[W-1]}}, WMAX})) return WMAX;
		if (v < $signed({{2{WMIN[W-1]}}, WMIN})) return WMIN;
		return v[W-1:0];
	endfunction

	// Truncate a full product toward zero to FRAC_BITS and saturate.
	function automatic logic signed [W-1:0] scale_sat(input logic signed [PW-1:0] p);
		logic               neg;
		logic [PW-1:0]      m;
		logic [PW-1:0]      sh;
		logic [PW-1:0]      lim;
		neg = p[PW-1];
		m   = neg ? -p : p;
		sh  = m >> FRAC_BITS;
		lim = neg ? (PW'(1) << (W - 1)) : ((PW'(1) << (W - 1)) - 1'b1);
		if (sh > lim) return neg ? WMIN : WMAX;
		return neg ? -sh[W-1:0] : sh[W-1:0];
	endfunction

	function automatic logic signed [W-1:0] in_word(input logic [31:0] v);
		return W'($signed(v[IW-1:0]));
	endfunction

	typedef enum logic [2:0] {
		S_IDLE, S_MUL1, S_MUL2, S_ACC, S_DIV0, S_DIV1, S_OUT
	} state_t;

	logic [CFG_BITS-1:0]   regs_q [8];
	logic signed [W-1:0]   v_q [NV];
	logic                  init_q;
	state_t                state_q;
	logic [UB-1:0]         pc_q;
	logic signed [PW-1:0]  prod_s1;
	logic signed [W-1:0]   t1_q;
	logic signed [W-1:0]   time_q;
	status_t               status_q;
	uop_t                  u;
	logic                  div_start_q;
	logic                  div_done;
	logic signed [W-1:0]   div_quo;
	logic signed [W-1:0]   mul_a;
	logic signed [W-1:0]   mul_b;
	logic signed [W+1:0]   acc_sum;
	logic signed [W-1:0]   acc_res;
	logic signed [W-1:0]   dt;
	logic [W-1:0]          time_next;

	assign u  = ucode(pc_q);
	assign dt = in_word(regs_q[REG_RDT][63:32]);
	assign time_next = time_q + dt;

	// Shared multiplier operand selection.
	assign mul_a = (state_q == S_MUL1) ? v_q[u.a] : v_q[u.c];
	assign mul_b = (state_q == S_MUL1) ? v_q[u.b] : v_q[u.d];

	// Combine the scaled products and the addend as the operation selects.
	always_comb begin
		unique case (u.op)
			OP_DOT:    acc_sum = (W+2)'(t1_q) + (W+2)'(scale_sat(prod_s1));
			OP_ADD:    acc_sum = (W+2)'(v_q[u.a]) + (W+2)'(v_q[u.e]);
			OP_SUBMUL: acc_sum = (W+2)'(v_q[u.e]) - (W+2)'(t1_q);
			OP_SUB:    acc_sum = (W+2)'(v_q[u.a]) - (W+2)'(v_q[u.e]);
			default:   acc_sum = '0;
		endcase
		acc_res = sat_w(acc_sum);
	end

	kfu_divider #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start_q),
		.num   ((state_q == S_DIV0) ? v_q[V_PC0] : v_q[V_PC1]),
		.den   (v_q[V_S]),
		.done  (div_done),
		.quo   (div_quo)
	);

	// Configuration register file.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q[REG_DYN0] <= 64'd65536;
			regs_q[REG_DYN1] <= 64'd281474976710656;
			regs_q[REG_OUT]  <= 64'd65536;
			regs_q[REG_Q0]   <= 64'd0;
			regs_q[REG_Q1]   <= 64'd0;
			regs_q[REG_RDT]  <= 64'd65536;
			regs_q[REG_P0]   <= 64'd65536;
			regs_q[REG_P1]   <= 64'd281474976710656;
		end else if (cfg_we) begin
			regs_q[cfg_idx] <= cfg_data;
		end
	end

	// Sequencer, shared datapath and filter state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pc_q        <= '0;
			init_q      <= 1'b0;
			out_valid   <= 1'b0;
			div_start_q <= 1'b0;
			time_q      <= '0;
			status_q    <= ST_OK;
			for (int i = 0; i < NV; i++) v_q[i] <= '0;
		end else begin
			div_start_q <= 1'b0;
			v_q[V_ZERO] <= '0;
			v_q[V_ONE]  <= sat_w((W+2)'(ONE_WIDE));
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (!in_data.kind) begin
							v_q[V_X0]  <= in_word(in_data.init_state0);
							v_q[V_X1]  <= in_word(in_data.init_state1);
							v_q[V_P00] <= in_word(regs_q[REG_P0][31:0]);
							v_q[V_P01] <= in_word(regs_q[REG_P0][63:32]);
							v_q[V_P10] <= in_word(regs_q[REG_P1][31:0]);
							v_q[V_P11] <= in_word(regs_q[REG_P1][63:32]);
							time_q     <= in_word(in_data.start_time);
							init_q     <= 1'b1;
							status_q   <= ST_OK;
							state_q    <= S_OUT;
							out_valid  <= 1'b1;
						end else if (!init_q) begin
							status_q  <= ST_NOT_READY;
							state_q   <= S_OUT;
							out_valid <= 1'b1;
						end else begin
							// Latch the coefficients and the measurement.
							v_q[V_A00] <= in_word(regs_q[REG_DYN0][31:0]);
							v_q[V_A01] <= in_word(regs_q[REG_DYN0][63:32]);
							v_q[V_A10] <= in_word(regs_q[REG_DYN1][31:0]);
							v_q[V_A11] <= in_word(regs_q[REG_DYN1][63:32]);
							v_q[V_C0]  <= in_word(regs_q[REG_OUT][31:0]);
							v_q[V_C1]  <= in_word(regs_q[REG_OUT][63:32]);
							v_q[V_Q00] <= in_word(regs_q[REG_Q0][31:0]);
							v_q[V_Q01] <= in_word(regs_q[REG_Q0][63:32]);
							v_q[V_Q10] <= in_word(regs_q[REG_Q1][31:0]);
							v_q[V_Q11] <= in_word(regs_q[REG_Q1][63:32]);
							v_q[V_R]   <= in_word(regs_q[REG_RDT][31:0]);
							v_q[V_Y]   <= in_word(in_data.measurement);
							pc_q       <= '0;
							state_q    <= S_MUL1;
						end
					end
				end
				S_MUL1: begin
					prod_s1 <= PW'(mul_a) * PW'(mul_b);
					state_q <= S_MUL2;
				end
				S_MUL2: begin
					t1_q    <= scale_sat(prod_s1);
					prod_s1 <= PW'(mul_a) * PW'(mul_b);
					state_q <= S_ACC;
				end
				S_ACC: begin
					v_q[u.dst] <= acc_res;
					if (pc_q == UB'(17)) begin
						if (acc_res <= 0) begin
							// Singular: commit the prediction only.
							v_q[V_X0]  <= v_q[V_XP0];
							v_q[V_X1]  <= v_q[V_XP1];
							v_q[V_P00] <= v_q[V_PP0];
							v_q[V_P01] <= v_q[V_PP1];
							v_q[V_P10] <= v_q[V_PP2];
							v_q[V_P11] <= v_q[V_PP3];
							time_q     <= time_next;
							status_q   <= ST_SINGULAR;
							state_q    <= S_OUT;
							out_valid  <= 1'b1;
						end else begin
							div_start_q <= 1'b1;
							state_q     <= S_DIV0;
						end
					end else if (pc_q == UB'(31)) begin
						time_q    <= time_next;
						status_q  <= ST_OK;
						state_q   <= S_OUT;
						out_valid <= 1'b1;
					end else begin
						pc_q    <= pc_q + 1'b1;
						state_q <= S_MUL1;
					end
				end
				S_DIV0: begin
					if (div_done) begin
						v_q[V_K0]   <= div_quo;
						div_start_q <= 1'b1;
						state_q     <= S_DIV1;
					end
				end
				S_DIV1: begin
					if (div_done) begin
						v_q[V_K1] <= div_quo;
						pc_q      <= UB'(18);
						state_q   <= S_MUL1;
					end
				end
				S_OUT: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready              = (state_q == S_IDLE);
	assign out_data.estimate0    = 32'(v_q[V_X0]);
	assign out_data.estimate1    = 32'(v_q[V_X1]);
	assign out_data.elapsed_time = 32'(time_q);
	assign out_data.status       = status_q;

	`KFU_ASSERT_IMPL(a_no_overlap, clk, arst_n, !(in_ready && out_valid), "input accepted while result pending")
	`KFU_ASSERT_NEXT(a_notready_keeps, clk, arst_n, in_valid && in_ready && in_data.kind && !init_q, status_q == ST_NOT_READY, "uninitialised measurement not flagged")
	`KFU_ASSERT_NEXT(a_init_sets, clk, arst_n, in_valid && in_ready && !in_data.kind, init_q && out_valid, "initialise did not complete")

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Kalman filter update testbench
// Drives initialise and measurement transfers with random idling and a long
// output back-pressure phase, predicts every result in fixed point and
// compares each output transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
	import kfu_pkg::*;

	localparam int FRAC = 16;
	localparam longint WMAX = 64'sd2147483647;
	localparam longint WMIN = -64'sd2147483648;
	localparam int CYCLE_LIMIT = 3000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0] cfg_idx = '0;
	logic [CFG_BITS-1:0] cfg_data = '0;

	// Filter state as predicted by the testbench.
	logic [63:0] kf_regs [8];
	longint kf_est [2];
	longint kf_cov [4];
	longint kf_time;
	bit kf_ready;

	out_item_t expected_results [$];
	int mismatches = 0;
	int cycles = 0;
	int sent = 0, checked = 0, n_meas = 0, n_singular = 0;
	bit idle_on = 1'b1;
	bit hold_output = 1'b0;

	kalman_filter_update_top DUT (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
		.out_data(out_data), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// Fixed-point helpers.
	function automatic longint sat_word(longint v);
		if (v > WMAX) return WMAX;
		if (v < WMIN) return WMIN;
		return v;
	endfunction

	function automatic longint word_half(logic [63:0] r, bit upper);
		logic signed [31:0] w;
		w = upper ? r[63:32] : r[31:0];
		return longint'(w);
	endfunction

	// Product truncated toward zero, then saturated; 128-bit product avoids overflow.
	function automatic longint fx_mul(longint a, longint b);
		logic signed [127:0] p;
		logic [127:0] m;
		bit neg;
		neg = (a < 0) != (b < 0);
		p = 128'(signed'(a)) * 128'(signed'(b));
		m = p < 0 ? -p : p;
		m = m >> FRAC;
		if (!neg && m > 128'(WMAX)) return WMAX;
		if (neg && m > 128'(64'h80000000)) return WMIN;
		return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
	endfunction

	function automatic longint fx_div(longint n, longint d);
		logic [127:0] un, q;
		bit neg;
		neg = n < 0;
		un = n < 0 ? 128'(-n) : 128'(n);
		q = (un << FRAC) / 128'(d);
		if (!neg && q > 128'(WMAX)) return WMAX;
		if (neg && q > 128'(64'h80000000)) return WMIN;
		return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
	endfunction

	function automatic longint fx_dot(longint a0, longint b0, longint a1, longint b1);
		return sat_word(fx_mul(a0, b0) + fx_mul(a1, b1));
	endfunction

	function automatic void kf_reset_state();
		kf_regs[REG_DYN0] = 64'd65536;
		kf_regs[REG_DYN1] = 64'd281474976710656;
		kf_regs[REG_OUT] = 64'd65536;
		kf_regs[REG_Q0] = 64'd0;
		kf_regs[REG_Q1] = 64'd0;
		kf_regs[REG_RDT] = 64'd65536;
		kf_regs[REG_P0] = 64'd65536;
		kf_regs[REG_P1] = 64'd281474976710656;
		kf_est = '{0, 0};
		kf_cov = '{0, 0, 0, 0};
		kf_time = 0;
		kf_ready = 1'b0;
	endfunction

	// Predict, gain, correct and covariance update for one measurement.
	function automatic status_t kf_measure(longint y);
		longint a [4], q [4], xp [2], ap [4], pp [4], m [4];
		longint c0, c1, r, dt, pc0, pc1, s, k0, k1, innov;
		logic [31:0] t;
		for (int i = 0; i < 4; i++) begin
			a[i] = word_half(kf_regs[REG_DYN0 + i / 2], i % 2);
			q[i] = word_half(kf_regs[REG_Q0 + i / 2], i % 2);
		end
		c0 = word_half(kf_regs[REG_OUT], 0);
		c1 = word_half(kf_regs[REG_OUT], 1);
		r = word_half(kf_regs[REG_RDT], 0);
		dt = word_half(kf_regs[REG_RDT], 1);
		xp[0] = fx_dot(a[0], kf_est[0], a[1], kf_est[1]);
		xp[1] = fx_dot(a[2], kf_est[0], a[3], kf_est[1]);
		ap[0] = fx_dot(a[0], kf_cov[0], a[1], kf_cov[2]);
		ap[1] = fx_dot(a[0], kf_cov[1], a[1], kf_cov[3]);
		ap[2] = fx_dot(a[2], kf_cov[0], a[3], kf_cov[2]);
		ap[3] = fx_dot(a[2], kf_cov[1], a[3], kf_cov[3]);
		pp[0] = sat_word(fx_dot(ap[0], a[0], ap[1], a[1]) + q[0]);
		pp[1] = sat_word(fx_dot(ap[0], a[2], ap[1], a[3]) + q[1]);
		pp[2] = sat_word(fx_dot(ap[2], a[0], ap[3], a[1]) + q[2]);
		pp[3] = sat_word(fx_dot(ap[2], a[2], ap[3], a[3]) + q[3]);
		pc0 = fx_dot(pp[0], c0, pp[1], c1);
		pc1 = fx_dot(pp[2], c0, pp[3], c1);
		s = sat_word(fx_dot(c0, pc0, c1, pc1) + r);
		t = 32'(kf_time + dt);
		kf_time = longint'(signed'(t));
		if (s <= 0) begin
			kf_est = xp;
			kf_cov = pp;
			return ST_SINGULAR;
		end
		k0 = fx_div(pc0, s);
		k1 = fx_div(pc1, s);
		innov = sat_word(y - fx_dot(c0, xp[0], c1, xp[1]));
		kf_est[0] = sat_word(xp[0] + fx_mul(k0, innov));
		kf_est[1] = sat_word(xp[1] + fx_mul(k1, innov));
		m[0] = sat_word(65536 - fx_mul(k0, c0));
		m[1] = sat_word(-fx_mul(k0, c1));
		m[2] = sat_word(-fx_mul(k1, c0));
		m[3] = sat_word(65536 - fx_mul(k1, c1));
		kf_cov[0] = fx_dot(m[0], pp[0], m[1], pp[2]);
		kf_cov[1] = fx_dot(m[0], pp[1], m[1], pp[3]);
		kf_cov[2] = fx_dot(m[2], pp[0], m[3], pp[2]);
		kf_cov[3] = fx_dot(m[2], pp[1], m[3], pp[3]);
		return ST_OK;
	endfunction

	function automatic out_item_t kf_update(in_item_t it);
		out_item_t res;
		status_t st;
		st = ST_OK;
		if (!it.kind) begin
			kf_est[0] = longint'(it.init_state0);
			kf_est[1] = longint'(it.init_state1);
			for (int i = 0; i < 4; i++) kf_cov[i] = word_half(kf_regs[REG_P0 + i / 2], i % 2);
			kf_time = longint'(it.start_time);
			kf_ready = 1'b1;
		end else if (!kf_ready) begin
			st = ST_NOT_READY;
		end else begin
			st = kf_measure(longint'(it.measurement));
			n_meas++;
			if (st == ST_SINGULAR) n_singular++;
		end
		res.estimate0 = kf_est[0][31:0];
		res.estimate1 = kf_est[1][31:0];
		res.elapsed_time = kf_time[31:0];
		res.status = st;
		return res;
	endfunction

	// Cycle counter and timeout.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Test completed with failures");
			$finish;
		end
	end

	// Output side: random stalls, or a long hold-off while the hold flag is set.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= !hold_output && (!idle_on || $urandom_range(99) >= 36);
		end
	end

	// Result checker.
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			checked++;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("Unexpected result transfer %p", out_data);
			end else begin
				want = expected_results.pop_front();
				if (out_data.estimate0 !== want.estimate0 || out_data.estimate1 !== want.estimate1
						|| out_data.elapsed_time !== want.elapsed_time
						|| out_data.status !== want.status) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Mismatch at result %0d: expected %p, got %p",
							checked, want, out_data);
				end
			end
		end
	end

	// Valid stays high into the next item unless the sender idles first.
	task automatic send_item(in_item_t it);
		while (idle_on && $urandom_range(99) < 36) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		expected_results.insert(expected_results.size(), kf_update(it));
		sent++;
	endtask

	task automatic write_reg(reg_idx_t idx, logic [63:0] value);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		kf_regs[idx] = value;
		@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	function automatic in_item_t make_item(bit kind, logic [31:0] y, logic [31:0] s0,
			logic [31:0] s1, logic [31:0] t0);
		in_item_t it;
		it.kind = kind;
		it.measurement = y;
		it.init_state0 = s0;
		it.init_state1 = s1;
		it.start_time = t0;
		return it;
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(5))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return $urandom;
			default: return 32'(signed'($urandom_range(20 * 65536)) - 10 * 65536);
		endcase
	endfunction

	function automatic logic [31:0] rand_small(int span);
		return 32'(int'($urandom_range(2 * span)) - span);
	endfunction

	// Measurements before initialisation, then word extremes.
	task automatic test_directed();
		send_item(make_item(1'b1, 32'h7fffffff, '0, '0, '0));
		send_item(make_item(1'b1, 32'h80000000, '1, '1, '1));
		send_item(make_item(1'b0, '0, 32'h00010000, 32'h00008000, 32'h00000000));
		send_item(make_item(1'b1, 32'h00020000, '0, '0, '0));
		send_item(make_item(1'b1, 32'h7fffffff, '0, '0, '0));
		send_item(make_item(1'b1, 32'h80000000, '0, '0, '0));
		send_item(make_item(1'b0, '0, 32'h7fffffff, 32'h80000000, 32'h7fff0000));
		send_item(make_item(1'b1, 32'hffffffff, '0, '0, '0));
		send_item(make_item(1'b1, 32'h00000000, '0, '0, '0));
		send_item(make_item(1'b0, 32'hffffffff, 32'h80000000, 32'h7fffffff, 32'h80000000));
		send_item(make_item(1'b1, 32'h12345678, '0, '0, '0));
		drain();
	endtask

	// Negative noise with zero covariance gives a singular innovation variance.
	task automatic test_singular();
		write_reg(REG_RDT, {32'h00010000, 32'hffff0000});
		write_reg(REG_P0, 64'd0);
		write_reg(REG_P1, 64'd0);
		send_item(make_item(1'b0, '0, 32'h00030000, 32'hfffe0000, 32'h00001000));
		repeat (3) send_item(make_item(1'b1, 32'h00050000, '0, '0, '0));
		drain();
		write_reg(REG_RDT, {32'hffffffff, 32'h00000000});
		send_item(make_item(1'b1, 32'h00050000, '0, '0, '0));
		drain();
	endtask

	// Saturating configuration: every register at an extreme, then all ones.
	task automatic test_extreme_config();
		for (int i = 0; i < 8; i++) write_reg(reg_idx_t'(i), {32'h7fffffff, 32'h80000000});
		send_item(make_item(1'b0, '0, 32'h00010000, 32'hffff0000, 32'h7fffffff));
		repeat (3) send_item(make_item(1'b1, rand_word(), '0, '0, '0));
		drain();
		for (int i = 0; i < 8; i++) write_reg(reg_idx_t'(i), '1);
		repeat (2) send_item(make_item(1'b1, rand_word(), '0, '0, '0));
		send_item(make_item(1'b0, '0, '1, '1, '1));
		send_item(make_item(1'b1, '1, '0, '0, '0));
		drain();
	endtask

	// A well-behaved constant-velocity tracker with random modest parameters.
	task automatic set_tracker_config();
		write_reg(REG_DYN0, {rand_small(32768), 32'h00010000 + rand_small(4096)});
		write_reg(REG_DYN1, {32'h00010000 + rand_small(4096), rand_small(8192)});
		write_reg(REG_OUT, {rand_small(16384), 32'h00010000 + rand_small(16384)});
		write_reg(REG_Q0, {rand_small(256), 32'($urandom_range(4096))});
		write_reg(REG_Q1, {32'($urandom_range(4096)), rand_small(256)});
		write_reg(REG_RDT, {32'($urandom_range(1 << 20)), 32'($urandom_range(1 << 18))});
		write_reg(REG_P0, {rand_small(65536), 32'($urandom_range(1 << 20))});
		write_reg(REG_P1, {32'($urandom_range(1 << 20)), rand_small(65536)});
	endtask

	// Random phases: mostly initialise-then-measure runs, some noise words.
	task automatic test_random(int phases, int per_phase);
		for (int ph = 0; ph < phases; ph++) begin
			if (ph % 5 == 4) begin
				for (int i = 0; i < 8; i++) write_reg(reg_idx_t'(i), {$urandom, $urandom});
			end else begin
				set_tracker_config();
			end
			idle_on = (ph % 4) != 2;
			send_item(make_item(1'b0, $urandom, rand_word(), rand_word(), rand_word()));
			for (int i = 0; i < per_phase; i++) begin
				if ($urandom_range(19) == 0)
					send_item(make_item(1'b0, $urandom, rand_word(), rand_word(), rand_word()));
				else
					send_item(make_item(1'b1, rand_word(), $urandom, $urandom, $urandom));
			end
			drain();
		end
		idle_on = 1'b1;
	endtask

	// Hold the output off for a long stretch while items keep arriving.
	task automatic test_backpressure();
		fork
			begin
				hold_output = 1'b1;
				repeat (2000) @(posedge clk);
				hold_output = 1'b0;
			end
			repeat (20) send_item(make_item(1'b1, rand_word(), '0, '0, '0));
		join
		drain();
	endtask

	initial begin
		kf_reset_state();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_singular();
		test_extreme_config();
		set_tracker_config();
		send_item(make_item(1'b0, '0, 32'h00010000, 32'h00020000, 32'h0));
		test_backpressure();
		test_random(50, 25);
		drain();
		$display("Sent %0d items, checked %0d results: %0d measurements, %0d singular.",
			sent, checked, n_meas, n_singular);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
